### sv/agi_pkg.sv
`timescale 1ns / 1ps
// agi_pkg: shared widths, beat types, controller states and the
// command/status structs of the adjacent pair gcd inserter; no dependencies

package agi_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int OPND_WIDTH  = DATA_WIDTH - 1;
    localparam int SHIFT_WIDTH = $clog2(DATA_WIDTH);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         start_of_list;
    } item_beat_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic                         is_gcd;
        logic                         last_of_item;
    } result_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT_GCD,
        ST_EMIT_VAL
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take;
        logic step;
        logic emit_gcd;
        logic emit_val;
    } agi_ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic pair;
        logic done;
        logic slot_free;
    } agi_status_t;

endpackage

### sv/agi_ctrl.sv
`timescale 1ns / 1ps
// agi_ctrl: sequencing state machine of the gcd inserter
// depends on agi_pkg for the state enum and command/status structs

module agi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  agi_pkg::agi_status_t status,
    output agi_pkg::agi_ctl_t    ctl
);
    import agi_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = status.pair ? ST_RUN : ST_EMIT_VAL;
                end
            end
            ST_RUN:
            begin
                if (status.done)
                begin
                    state_next = ST_EMIT_GCD;
                end
            end
            ST_EMIT_GCD:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_EMIT_VAL;
                end
            end
            ST_EMIT_VAL:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall   = 1'b1;
        ctl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                ctl.take   = item_valid;
            end
            ST_RUN:
            begin
                ctl.step = !status.done;
            end
            ST_EMIT_GCD:
            begin
                ctl.emit_gcd = status.slot_free;
            end
            ST_EMIT_VAL:
            begin
                ctl.emit_val = status.slot_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

### sv/agi_datapath.sv
`timescale 1ns / 1ps
// agi_datapath: previous-value store, binary gcd unit and output register
// depends on agi_pkg for widths, beat types and command/status structs

module agi_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  agi_pkg::item_beat_t   item,
    input  agi_pkg::agi_ctl_t     ctl,
    output agi_pkg::agi_status_t  status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output agi_pkg::result_beat_t result
);
    import agi_pkg::*;

    logic [DATA_WIDTH-1:0]  prev_reg;
    logic                   have_prev_reg;
    logic [DATA_WIDTH-1:0]  cur_reg;
    logic [OPND_WIDTH-1:0]  a_reg;
    logic [OPND_WIDTH-1:0]  a_next;
    logic [OPND_WIDTH-1:0]  b_reg;
    logic [OPND_WIDTH-1:0]  b_next;
    logic [SHIFT_WIDTH-1:0] k_reg;
    logic [SHIFT_WIDTH-1:0] k_next;
    result_beat_t           out_reg;
    result_beat_t           out_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   prev_pos;
    logic                   cur_pos;
    logic [DATA_WIDTH-1:0]  gcd_value;

    assign prev_pos = (prev_reg != '0) && !prev_reg[DATA_WIDTH-1];
    assign cur_pos  = (item.value != '0) && !item.value[DATA_WIDTH-1];

    assign status.pair      = !item.start_of_list && have_prev_reg;
    assign status.done      = (a_reg == '0) || (b_reg == '0);
    assign status.slot_free = !out_valid_reg || !result_stall;

    // common power of two restored at the end
    assign gcd_value = {1'b0, a_reg | b_reg} << k_reg;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (ctl.take)
        begin
            // non-positive operand: a=1, b=0 finishes at once with gcd 1
            if (prev_pos && cur_pos)
            begin
                a_next = prev_reg[OPND_WIDTH-1:0];
                b_next = item.value[OPND_WIDTH-1:0];
            end
            else
            begin
                a_next = OPND_WIDTH'(1);
                b_next = '0;
            end
            k_next = '0;
        end
        else if (ctl.step)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + SHIFT_WIDTH'(1);
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (ctl.emit_gcd)
        begin
            out_next.result_value = gcd_value;
            out_next.is_gcd       = 1'b1;
            out_next.last_of_item = 1'b0;
            out_valid_next        = 1'b1;
        end
        else if (ctl.emit_val)
        begin
            out_next.result_value = cur_reg;
            out_next.is_gcd       = 1'b0;
            out_next.last_of_item = 1'b1;
            out_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctl.take)
            begin
                prev_reg      <= item.value;
                have_prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        out_reg <= out_next;
        if (ctl.take)
        begin
            cur_reg <= item.value;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### sv/adjacent_pair_gcd_inserter.sv
`timescale 1ns / 1ps
// adjacent_pair_gcd_inserter: top level joining controller and datapath
// depends on agi_pkg, agi_ctrl and agi_datapath

// One item is worked at a time. An unpaired item (first of a list, or the first
// after reset) is accepted, then loaded into the output register, and gives one
// beat. A paired item gives a gcd beat and then the value beat; its time is set
// by the binary gcd loop, one shift-or-subtract step per cycle, up to about
// 2*(DATA_WIDTH-1) steps (about 62 for 32-bit values), before the two beats are
// loaded into the output register in turn. When either operand is zero or
// negative the loop finishes at once. The output register lets the next item be
// accepted while the last beat still waits.

module adjacent_pair_gcd_inserter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  agi_pkg::item_beat_t   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output agi_pkg::result_beat_t result
);
    import agi_pkg::*;

    agi_ctl_t    ctl;
    agi_status_t status;

    agi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .ctl        (ctl)
    );

    agi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctl          (ctl),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTH
    // a gcd beat is never the last of its item, a value beat always is
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.is_gcd != result.last_of_item))
        else $error("is_gcd and last_of_item disagree");

    // one item at a time: an accepted item blocks the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item accepted while another is in work");

    // the inserted gcd is always positive
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_gcd) |->
            (!result.result_value[DATA_WIDTH-1] && result.result_value != '0))
        else $error("inserted gcd not positive");

    // the gcd unit only steps while it has not finished
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> !status.done)
        else $error("gcd step after completion");
`endif

endmodule

### test/gcd_pair_checker.sv
`timescale 1ns / 1ps
// gcd_pair_checker: watches the item and result channels of the adjacent pair
// gcd inserter, predicts every result beat and compares; depends on agi_pkg

module gcd_pair_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  agi_pkg::item_beat_t   item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  agi_pkg::result_beat_t result,
    output int                    errors,
    output int                    pending
);

    localparam int W          = agi_pkg::DATA_WIDTH;
    localparam int PRINT_LIMIT = 100;

    logic signed [W-1:0]   last_value;
    logic                  have_last;
    agi_pkg::result_beat_t expected_beats[$];

    initial errors = 0;
    initial pending = 0;

    // divisor of two neighbors; any operand that is not strictly positive gives 1
    function automatic logic [W-1:0] neighbor_divisor(input logic signed [W-1:0] a,
                                                      input logic signed [W-1:0] b);
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] r;
        if (a <= 0 || b <= 0)
            return W'(1);
        x = a;
        y = b;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        if (errors < PRINT_LIMIT)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        agi_pkg::result_beat_t want;
        agi_pkg::result_beat_t beat;
        if (!rst_n)
        begin
            last_value = '0;
            have_last  = 1'b0;
            expected_beats.delete();
            pending <= 0;
        end
        else
        begin
            // check the outgoing beat before queueing anything new
            if (result_valid && !result_stall)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("result beat with nothing expected", result.result_value, '0);
                else
                begin
                    want = expected_beats.pop_front();
                    if (result.result_value !== want.result_value)
                        report_mismatch("result_value", result.result_value, want.result_value);
                    if (result.is_gcd !== want.is_gcd)
                        report_mismatch("is_gcd", W'(result.is_gcd), W'(want.is_gcd));
                    if (result.last_of_item !== want.last_of_item)
                        report_mismatch("last_of_item", W'(result.last_of_item),
                                        W'(want.last_of_item));
                end
            end
            if (item_valid && !item_stall)
            begin
                if (!item.start_of_list && have_last)
                begin
                    beat.result_value = neighbor_divisor(last_value, item.value);
                    beat.is_gcd       = 1'b1;
                    beat.last_of_item = 1'b0;
                    expected_beats.push_back(beat);
                end
                beat.result_value = item.value;
                beat.is_gcd       = 1'b0;
                beat.last_of_item = 1'b1;
                expected_beats.push_back(beat);
                last_value = item.value;
                have_last  = 1'b1;
            end
            pending <= expected_beats.size();
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// tb: stimulus, random idling on both channels and verdict for the adjacent
// pair gcd inserter; depends on agi_pkg, the block and gcd_pair_checker

module tb;

    import agi_pkg::*;

    localparam int W            = DATA_WIDTH;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASE_ITEMS  = 50;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 70;

    localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_stall;
    item_beat_t   item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_beat_t result;

    int errors;
    int pending;
    int src_max = 0;
    int sink_max = 0;
    int sink_wait = 0;
    int quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    adjacent_pair_gcd_inserter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    gcd_pair_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    // receiver: after each accepted beat, stall for a fresh random count
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sink_wait = $urandom_range(0, sink_max);
            result_stall <= (sink_wait != 0);
        end
        else if (sink_wait > 0)
        begin
            sink_wait--;
            result_stall <= (sink_wait != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles <= 0;
        else
        begin
            if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic signed [W-1:0] v, input logic first);
        int gap;
        gap = $urandom_range(0, src_max);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= {v, first};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // four draws in ten are multiples of a per-sequence factor so the divisors are not all 1
    function automatic logic signed [W-1:0] draw_value(input logic [W-1:0] factor);
        case ($urandom_range(0, 9))
            0:          return $urandom;
            1:          return ($urandom_range(0, 3) == 0) ? '0 : ($urandom | MIN_NEG);
            2, 3, 4, 5: return factor * $urandom_range(1, 32767);
            6, 7:       return $urandom & MAX_POS;
            8:          return $urandom_range(1, 16);
            default:    return $urandom_range(0, 1) ? MAX_POS - $urandom_range(0, 15)
                                                    : 1 << $urandom_range(0, W - 2);
        endcase
    endfunction

    initial
    begin
        logic [W-1:0] factor;
        logic         first;
        factor = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_max  = 3;
        sink_max = 3;
        // continuation straight after reset acts as a new sequence
        send_item(12, 1'b0);
        send_item(18, 1'b0);
        send_item(0, 1'b0);
        send_item(5, 1'b0);
        send_item(-7, 1'b0);
        send_item(MIN_NEG, 1'b0);
        send_item(MAX_POS, 1'b0);
        send_item(MAX_POS, 1'b0);
        send_item(1, 1'b0);
        send_item(32'sd1073741824, 1'b1);
        send_item(32'sd1048576, 1'b0);
        // consecutive fibonacci numbers: the longest euclid chain
        send_item(32'sd1836311903, 1'b0);
        send_item(32'sd1134903170, 1'b0);
        send_item(-1, 1'b1);
        send_item(-1, 1'b0);
        send_item(MAX_POS - 1, 1'b1);
        send_item(32'sd1073741823, 1'b0);
        send_item(32'sd715827882, 1'b0);
        send_item(1, 1'b1);
        send_item(1, 1'b0);
        send_item(0, 1'b1);
        send_item(0, 1'b0);
        send_item(32'sd65536, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                src_max  = ($urandom_range(0, 2) == 0) ? 0 : 7;
                sink_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
            end
            first = ($urandom_range(0, 7) == 0);
            if (first)
                factor = $urandom_range(0, 1) ? $urandom_range(1, 65535)
                                              : 1 << $urandom_range(0, 15);
            send_item(draw_value(factor), first);
        end
        item_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
